[rtl/chained_hash_map_assert.svh]
// assertion macros shared by the checker
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH
// implication checked on every rising clock edge out of reset
`define CHM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chm check failed");
// next-cycle implication
`define CHM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chm check failed");
`endif

[rtl/chm_pkg.sv]
`default_nettype none
package chm_pkg;
  localparam int Buckets = 64;
  localparam int Entries = 256;
  localparam int BW = $clog2(Buckets);
  localparam int NW = $clog2(Entries);
  localparam int CW = NW + 1;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_GET = 2'd1,
    KIND_REM = 2'd2,
    KIND_NOP = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_NEGATIVE = 3'd5,
    ST_FULL     = 3'd6
  } status_t;
endpackage
`default_nettype wire

[rtl/chained_hash_map.sv]
// flow: an accepted request goes to S_HEAD, then S_NODE and S_CMP for each node walked, and
//   on to S_DONE; an empty bucket skips S_NODE, a negative key or an unused kind goes straight to S_DONE
// throughput: one request at a time, the next accepted the cycle after the result is taken
// reset: rst_n synchronous active low; clears bucket valid bits and free stack written flags,
//   sets the free count to Entries, no clearing pass; node memories are never used before being written
`default_nettype none
module chained_hash_map (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key[31:0], value[63:32]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // status[2:0], found_value[34:3], zero[39:35]
);
  localparam int NW = chm_pkg::NW;
  localparam int BW = chm_pkg::BW;
  localparam int CW = chm_pkg::CW;

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_NODE, S_CMP, S_DONE} state_t;

  // bucket head table: valid bits in flops, indexes in memory
  logic [chm_pkg::Buckets-1:0] head_vld_r;
  logic [NW-1:0] head_mem [chm_pkg::Buckets];
  // node pool
  logic [30:0]   key_mem  [chm_pkg::Entries];
  logic [31:0]   val_mem  [chm_pkg::Entries];
  logic [NW:0]   link_mem [chm_pkg::Entries]; // {valid, index}
  // free stack; entry i below the first push reads as i
  logic [NW-1:0] free_mem [chm_pkg::Entries];
  logic [chm_pkg::Entries-1:0] free_wr_r;
  logic [CW-1:0] free_cnt_r;

  state_t        state_r;
  chm_pkg::kind_t kind_r;
  logic [30:0]   key_r;
  logic [31:0]   val_r;
  logic [BW-1:0] bkt_r;
  logic [NW-1:0] cur_r, prev_r;
  logic          has_prev_r;
  logic [NW-1:0] head_rd_r, free_rd_r;
  logic          free_rd_wr_r;
  logic [30:0]   key_rd_r;
  logic [31:0]   val_rd_r;
  logic [NW:0]   link_rd_r;
  logic [2:0]    st_r;
  logic [31:0]   fv_r;

  // head index captured at S_HEAD, held for the insert link
  logic [NW-1:0] head_mem_rd_fix;
  logic [NW-1:0] head_hold_r;

  logic [NW-1:0] free_top;
  logic [NW-1:0] new_node;
  assign free_top = free_cnt_r[NW-1:0] - 1'b1;
  assign new_node = free_rd_wr_r ? free_rd_r : free_top;

  assign in_tready = (state_r == S_IDLE);
  assign out_tdata = {5'd0, fv_r, st_r};

  // synchronous reads
  always_ff @(posedge clk) begin
    head_rd_r    <= head_mem[in_tdata[BW-1:0]];
    free_rd_r    <= free_mem[free_top];
    free_rd_wr_r <= free_wr_r[free_top];
    key_rd_r     <= key_mem[cur_r];
    val_rd_r     <= val_mem[cur_r];
    link_rd_r    <= link_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_tvalid <= 1'b0;
      head_vld_r <= '0;
      free_wr_r  <= '0;
      free_cnt_r <= CW'(chm_pkg::Entries);
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r     <= chm_pkg::kind_t'(in_tuser);
            key_r      <= in_tdata[30:0];
            val_r      <= in_tdata[63:32];
            bkt_r      <= in_tdata[BW-1:0];
            has_prev_r <= 1'b0;
            fv_r       <= '0;
            if (in_tdata[31]) begin
              st_r <= chm_pkg::ST_NEGATIVE;
              state_r <= S_DONE;
              out_tvalid <= 1'b1;
            end else if (chm_pkg::kind_t'(in_tuser) == chm_pkg::KIND_NOP) begin
              st_r <= chm_pkg::ST_ABSENT;
              state_r <= S_DONE;
              out_tvalid <= 1'b1;
            end else begin
              state_r <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          cur_r <= head_rd_r;
          if (head_vld_r[bkt_r]) state_r <= S_NODE;
          else state_r <= S_CMP; // miss, finish below
        end
        S_NODE: state_r <= S_CMP; // node read in flight
        S_CMP: begin
          if (head_vld_r[bkt_r] && key_rd_r == key_r) begin
            // hit at cur_r
            unique case (kind_r)
              chm_pkg::KIND_ADD: begin
                val_mem[cur_r] <= val_r;
                st_r <= chm_pkg::ST_UPDATED;
              end
              chm_pkg::KIND_GET: begin
                fv_r <= val_rd_r;
                st_r <= chm_pkg::ST_FOUND;
              end
              default: begin
                if (has_prev_r) link_mem[prev_r] <= link_rd_r;
                else begin
                  head_vld_r[bkt_r] <= link_rd_r[NW];
                  head_mem[bkt_r]   <= link_rd_r[NW-1:0];
                end
                if (free_cnt_r < CW'(chm_pkg::Entries)) begin
                  free_mem[free_cnt_r[NW-1:0]]  <= cur_r;
                  free_wr_r[free_cnt_r[NW-1:0]] <= 1'b1;
                  free_cnt_r <= free_cnt_r + 1'b1;
                end
                st_r <= chm_pkg::ST_REMOVED;
              end
            endcase
            state_r <= S_DONE;
            out_tvalid <= 1'b1;
          end else if (head_vld_r[bkt_r] && link_rd_r[NW]) begin
            // advance along the chain
            prev_r     <= cur_r;
            has_prev_r <= 1'b1;
            cur_r      <= link_rd_r[NW-1:0];
            state_r    <= S_NODE;
          end else begin
            // miss
            if (kind_r == chm_pkg::KIND_ADD) begin
              if (free_cnt_r == '0) begin
                st_r <= chm_pkg::ST_FULL;
              end else begin
                key_mem[new_node]  <= key_r;
                val_mem[new_node]  <= val_r;
                link_mem[new_node] <= {head_vld_r[bkt_r], head_mem_rd_fix};
                head_mem[bkt_r]    <= new_node;
                head_vld_r[bkt_r]  <= 1'b1;
                free_cnt_r <= free_cnt_r - 1'b1;
                st_r <= chm_pkg::ST_INSERTED;
              end
            end else begin
              st_r <= chm_pkg::ST_ABSENT;
            end
            state_r <= S_DONE;
            out_tvalid <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_HEAD) head_hold_r <= head_rd_r;
  end
  assign head_mem_rd_fix = head_hold_r;
endmodule
`default_nettype wire

[rtl/chm_checker.sv]
`default_nettype none
`include "chained_hash_map_assert.svh"
module chm_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [63:0] in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  // never accepts while a result waits
  `CHM_ASSERT_IMP(no_overlap, out_tvalid, !in_tready)
  // negative key gets the negative status
  `CHM_ASSERT_NEXT(neg_key, in_tvalid && in_tready && in_tdata[31],
    out_tvalid && out_tdata[2:0] == chm_pkg::ST_NEGATIVE)
  // only a found status carries a value
  `CHM_ASSERT_IMP(val_zero, out_tvalid && out_tdata[2:0] != chm_pkg::ST_FOUND,
    out_tdata[34:3] == 32'd0)
  // result stays until taken
  `CHM_ASSERT_NEXT(hold_out, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind chained_hash_map chm_props u_chm_props (.*);
`default_nettype wire

[verif/chm_checker.sv]
`default_nettype none
module chm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    chm_pkg::status_t status;
    logic [31:0]      found_value;
  } answer_t;

  // shadow map state
  logic                  head_ok [chm_pkg::Buckets];
  logic [chm_pkg::NW-1:0] head_idx [chm_pkg::Buckets];
  logic [30:0]           key_mem [chm_pkg::Entries];
  logic [31:0]           val_mem [chm_pkg::Entries];
  logic                  link_ok [chm_pkg::Entries];
  logic [chm_pkg::NW-1:0] link_idx [chm_pkg::Entries];
  logic [chm_pkg::NW-1:0] free_list [chm_pkg::Entries];
  int                    free_left;
  answer_t               answers[$];

  function automatic answer_t apply_request(chm_pkg::kind_t kind, logic [31:0] key,
                                            logic [31:0] value);
    answer_t a;
    int b, cur, prv, n;
    logic ok, hit, has_prv;
    a.status = chm_pkg::ST_ABSENT;
    a.found_value = '0;
    hit = 0;
    has_prv = 0;
    prv = 0;
    cur = 0;
    if (key[31]) begin
      a.status = chm_pkg::ST_NEGATIVE;
      return a;
    end
    if (kind == chm_pkg::KIND_NOP) return a;
    b = key % chm_pkg::Buckets;
    ok = head_ok[b];
    cur = head_idx[b];
    for (n = 0; ok && n < chm_pkg::Entries && !hit; n++) begin
      if (key_mem[cur] == key[30:0]) begin
        hit = 1;
      end else begin
        has_prv = 1;
        prv = cur;
        ok = link_ok[cur];
        cur = link_idx[cur];
      end
    end
    case (kind)
      chm_pkg::KIND_ADD: begin
        if (hit) begin
          val_mem[cur] = value;
          a.status = chm_pkg::ST_UPDATED;
        end else if (free_left == 0) begin
          a.status = chm_pkg::ST_FULL;
        end else begin
          free_left--;
          cur = free_list[free_left];
          key_mem[cur] = key[30:0];
          val_mem[cur] = value;
          link_ok[cur] = head_ok[b];
          link_idx[cur] = head_idx[b];
          head_ok[b] = 1;
          head_idx[b] = cur;
          a.status = chm_pkg::ST_INSERTED;
        end
      end
      chm_pkg::KIND_GET: begin
        if (hit) begin
          a.status = chm_pkg::ST_FOUND;
          a.found_value = val_mem[cur];
        end
      end
      default: begin
        if (hit) begin
          if (has_prv) begin
            link_ok[prv] = link_ok[cur];
            link_idx[prv] = link_idx[cur];
          end else begin
            head_ok[b] = link_ok[cur];
            head_idx[b] = link_idx[cur];
          end
          link_ok[cur] = 0;
          if (free_left < chm_pkg::Entries) begin
            free_list[free_left] = cur;
            free_left++;
          end
          a.status = chm_pkg::ST_REMOVED;
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < chm_pkg::Buckets; i++) head_ok[i] = 0;
      for (int i = 0; i < chm_pkg::Entries; i++) begin
        free_list[i] = i;
        link_ok[i] = 0;
        key_mem[i] = '0;
      end
      free_left = chm_pkg::Entries;
      answers.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        answers.push_back(apply_request(chm_pkg::kind_t'(in_tuser), in_tdata[31:0],
                                        in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = answers.pop_front();
          if (out_tdata[2:0] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_tdata[2:0]);
            fail_count++;
          end
          if (out_tdata[34:3] !== want.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time,
                     want.found_value, out_tdata[34:3]);
            fail_count++;
          end
          if (out_tdata[39:35] !== 5'd0) begin
            $display("%0t: pad expected 0 actual %h", $time, out_tdata[39:35]);
            fail_count++;
          end
        end
      end
    end
    pending = answers.size();
  end
endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
  localparam int StallLimit = 2000;   // cycles with no word moving on either side

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // key[31:0], value[63:32]
  logic [1:0]  in_tuser = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;       // status[2:0], found_value[34:3], zero[39:35]
  int          fail_count;
  int          pending;
  int          quiet;
  int          out_wait;
  int          out_gap;
  logic        sending = 1;
  int          keys_live[$];    // keys likely present, to aim gets and removes

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  chained_hash_map dut (.*);

  chm_checker check (.*);

  // send one word, with a random idle gap in front
  task automatic send_word(chm_pkg::kind_t kind, logic [31:0] key, logic [31:0] value);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= {value, key};
    do @(posedge clk); while (!in_tready);
  endtask

  // random non-negative key, mostly from a small set so chains collide
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return {1'b0, 31'($urandom)};
      1, 2, 3: return $urandom_range(0, 7) * chm_pkg::Buckets + $urandom_range(0, 3);
      default: begin
        if (keys_live.size() != 0)
          return keys_live[$urandom_range(0, keys_live.size() - 1)];
        return $urandom_range(0, 300);
      end
    endcase
  endfunction

  // receiver: after each word taken, holds ready low for a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      out_wait   <= 0;
    end else if (out_tvalid && out_tready) begin
      out_gap = $urandom_range(0, 6);
      out_wait   <= out_gap;
      out_tready <= (out_gap == 0);
    end else if (out_wait > 1) begin
      out_wait <= out_wait - 1;
    end else begin
      out_wait   <= 0;
      out_tready <= 1;
    end
  end

  // watchdog over idle handshakes
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet <= 0;
    else if (sending || pending != 0)
      quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("chained_hash_map regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] k;
    chm_pkg::kind_t kd;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every kind, every special case
    send_word(chm_pkg::KIND_GET, 32'd5, 32'd0);                 // get on empty map
    send_word(chm_pkg::KIND_REM, 32'd5, 32'd0);                 // remove absent
    send_word(chm_pkg::KIND_ADD, 32'd0, 32'h7fff_ffff);
    send_word(chm_pkg::KIND_ADD, 32'h7fff_ffff, 32'h8000_0000);
    send_word(chm_pkg::KIND_ADD, 32'd64, 32'hffff_ffff);        // same bucket as key zero
    send_word(chm_pkg::KIND_ADD, 32'd128, 32'h1234_5678);
    send_word(chm_pkg::KIND_GET, 32'd0, 32'd0);                 // tail of the chain
    send_word(chm_pkg::KIND_ADD, 32'd0, 32'h0000_0001);         // update
    send_word(chm_pkg::KIND_REM, 32'd64, 32'd0);                // middle of the chain
    send_word(chm_pkg::KIND_GET, 32'd0, 32'd0);
    send_word(chm_pkg::KIND_GET, 32'd128, 32'd0);
    send_word(chm_pkg::KIND_REM, 32'd128, 32'd0);               // head of the chain
    send_word(chm_pkg::KIND_GET, 32'h7fff_ffff, 32'd0);
    send_word(chm_pkg::KIND_ADD, 32'h8000_0000, 32'd9);         // negative key
    send_word(chm_pkg::KIND_GET, 32'hffff_ffff, 32'd0);
    send_word(chm_pkg::KIND_REM, 32'h8000_0001, 32'd0);
    send_word(chm_pkg::KIND_NOP, 32'd0, 32'd0);                 // unused kind
    send_word(chm_pkg::KIND_NOP, 32'hffff_ffff, 32'hffff_ffff);

    // fill the pool to overflow, then update while full
    for (int i = 0; i < chm_pkg::Entries + 3; i++)
      send_word(chm_pkg::KIND_ADD, 32'(1000 + i), $urandom);
    send_word(chm_pkg::KIND_ADD, 32'd1000, 32'hdead_beef);
    send_word(chm_pkg::KIND_GET, 32'd1000, 32'd0);
    for (int i = 0; i < chm_pkg::Entries + 3; i++)
      send_word(chm_pkg::KIND_REM, 32'(1000 + i), 32'd0);

    // random mix, mostly aimed at live keys
    for (int i = 0; i < 900; i++) begin
      k = pick_key();
      if ($urandom_range(0, 19) == 0) k[31] = 1;
      kd = chm_pkg::kind_t'($urandom_range(0, 9) < 4 ? chm_pkg::KIND_ADD
                   : ($urandom_range(0, 1) ? chm_pkg::KIND_GET : chm_pkg::KIND_REM));
      if ($urandom_range(0, 30) == 0) kd = chm_pkg::KIND_NOP;
      if (kd == chm_pkg::KIND_ADD && !k[31] && keys_live.size() < 200) keys_live.push_back(k);
      send_word(kd, k, $urandom);
    end
    in_tvalid <= 0;
    sending = 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("chained_hash_map regression: pass");
    else
      $display("chained_hash_map regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
